// ===== hdl/planar_thrust_dynamics_step_assert.svh =====
// Assertion macros shared by the planar thrust dynamics RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef PLANAR_THRUST_DYNAMICS_STEP_ASSERT_SVH
`define PLANAR_THRUST_DYNAMICS_STEP_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only out of reset
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define PTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PTS_ASSERT(lbl, prop, msg)
`define PTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/pts_pkg.sv =====
// Types, constants and helper functions for the planar thrust dynamics block.
// No dependencies; used by the interfaces, the multiply unit and the top level.
package pts_pkg;

  localparam int unsigned CORDIC_ITER_DEF = 24;
  localparam int unsigned CFG_IDX_W       = 4;

  localparam logic signed [33:0] PI_Q24          = 34'sd52707179;
  localparam logic signed [33:0] HALF_PI_Q24     = 34'sd26353589;
  localparam logic signed [33:0] TWO_PI_Q24      = 34'sd105414357;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [2:0] {
    REG_STEP_TIME  = 3'd0,
    REG_POS_GAIN   = 3'd1,
    REG_ANG_GAIN   = 3'd2,
    REG_VEL_GAIN   = 3'd3,
    REG_TURN_GAIN  = 3'd4,
    REG_DRAG       = 3'd5,
    REG_TURN_DRAG  = 3'd6,
    REG_LEVER_ARM  = 3'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_REDUCE, ST_FOLD, ST_ROTATE, ST_MUL_START, ST_MUL_WAIT, ST_COMMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MS_IDLE, MS_LO, MS_HI, MS_COMBINE
  } mul_state_e;

  typedef enum logic [4:0] {
    OP_SUM_COS, OP_NSQ, OP_FN, OP_SUM_SIN, OP_ESQ, OP_FE, OP_DIF_ARM, OP_TSQ, OP_FA,
    OP_NP_RATE, OP_NP_FORCE, OP_EP_RATE, OP_EP_FORCE, OP_HD_RATE, OP_HD_FORCE,
    OP_NR, OP_ER, OP_TR, OP_COST_L, OP_COST_R
  } op_e;

  typedef enum logic [1:0] {
    OPK_LOAD, OPK_ADD, OPK_SUB
  } op_kind_e;

  typedef enum logic [3:0] {
    DST_TMP, DST_SQ, DST_FN, DST_FE, DST_FA, DST_NP, DST_EP, DST_HD,
    DST_NR, DST_ER, DST_TR, DST_C1
  } op_dest_e;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [33:0] b;
    logic [5:0]         sh;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043837;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048576;
      5'd31:   r = 34'sd0;
      default: r = $signed(34'(34'd1 << (5'd30 - i)));
    endcase
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -64'sh0000_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

// ===== hdl/pts_if.sv =====
// Channel interfaces: thrust input, state result and configuration write.
// Depends on pts_pkg for the register index width.
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_thrust;
  logic [31:0] right_thrust;
  modport source (output valid, left_thrust, right_thrust, input ready);
  modport sink   (input valid, left_thrust, right_thrust, output ready);
endinterface

interface pts_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] north_position;
  logic signed [47:0] east_position;
  logic signed [31:0] heading_angle;
  logic signed [31:0] north_velocity;
  logic signed [31:0] east_velocity;
  logic signed [31:0] turn_velocity;
  logic [31:0]        effort_cost;
  modport source (output valid, north_position, east_position, heading_angle,
                  north_velocity, east_velocity, turn_velocity, effort_cost,
                  input ready);
  modport sink   (input valid, north_position, east_position, heading_angle,
                  north_velocity, east_velocity, turn_velocity, effort_cost,
                  output ready);
endinterface

interface pts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pts_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pts_mulshift.sv =====
// Shared multiply-scale-saturate unit: sign(a*b)*floor(|a|*|b|/2^sh), saturated.
// One 32x34 multiplier used twice per operation. Depends on pts_pkg.
module pts_mulshift (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pts_pkg::mul_req_t   req_i,
  output pts_pkg::mul_stat_t  stat_o,
  output logic signed [63:0]  result_o
);
  import pts_pkg::*;

  mul_state_e state_q, state_d;
  logic [63:0] ma_q;
  logic [33:0] mb_q;
  logic        neg_q;
  logic [5:0]  sh_q;
  logic [65:0] plo_q, phi_q;

  logic [31:0] mul_a;
  logic [65:0] prod;
  logic [6:0]  sat_sh;
  logic        sat;
  logic [66:0] mag;
  logic [63:0] mag_c;

  assign mul_a = (state_q == MS_HI) ? ma_q[63:32] : ma_q[31:0];
  assign prod  = 66'(mul_a) * 66'(mb_q);

  assign sat_sh = 7'd31 + 7'(sh_q);
  assign sat    = (phi_q >> sat_sh) != 66'd0;
  assign mag    = 67'(phi_q << (7'd32 - 7'(sh_q))) + 67'(plo_q >> sh_q);
  assign mag_c  = (sat || mag > 67'(S64_MAX)) ? S64_MAX : mag[63:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      MS_IDLE:    if (req_i.start) state_d = MS_LO;
      MS_LO:      state_d = MS_HI;
      MS_HI:      state_d = MS_COMBINE;
      MS_COMBINE: state_d = MS_IDLE;
      default:    state_d = MS_IDLE;
    endcase
  end

  always_comb begin
    stat_o.busy = (state_q != MS_IDLE);
    stat_o.done = (state_q == MS_COMBINE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MS_IDLE: begin
        if (req_i.start) begin
          ma_q  <= req_i.a[63] ? 64'(-req_i.a) : req_i.a;
          mb_q  <= req_i.b[33] ? 34'(-req_i.b) : req_i.b;
          neg_q <= req_i.a[63] ^ req_i.b[33];
          sh_q  <= req_i.sh;
        end
      end
      MS_LO:   plo_q <= prod;
      MS_HI:   phi_q <= prod;
      default: ;
    endcase
  end

  // valid while done is high
  assign result_o = neg_q ? -$signed(mag_c) : $signed(mag_c);

endmodule

// ===== hdl/planar_thrust_dynamics_step.sv =====
// Planar two-thruster rigid body, one integration step per input beat.
// Channels: in_i carries left/right thrust codes (2^31 = zero force); out_o
// returns the new state (positions Q32.16, heading Q8.24, rates Q16.16) and
// the effort cost; cfg_i writes the eight Q16.16 registers by index, always
// ready, and must only be used while the block is idle.
// From the accepting edge to out_o.valid: heading reduction (one 2*pi step per
// cycle plus the in-range check), a fold state, CORDIC_ITERATIONS rotation
// iterations, twenty multiply-scale operations in sequence on the one shared
// multiplier, then a commit state that waits while a result is pending.
// in_i.ready is high only when idle, from the cycle after the commit, so a
// new beat is not accepted until the previous one has been committed.
// Reset clears the body to rest at the origin with heading zero and loads
// the register defaults. The result sits in an output register; if the
// receiver stalls, the next beat may be accepted and computed, but its
// commit waits until the pending result has been taken.
// Depends on pts_pkg, the channel interfaces and pts_mulshift.
`include "planar_thrust_dynamics_step_assert.svh"
module planar_thrust_dynamics_step #(
  parameter int unsigned CORDIC_ITERATIONS = pts_pkg::CORDIC_ITER_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pts_in_if.sink      in_i,
  pts_out_if.source   out_o,
  pts_cfg_if.sink     cfg_i
);
  import pts_pkg::*;

  localparam int unsigned IW = $clog2(CORDIC_ITERATIONS);

  ctrl_state_e state_q, state_d;
  op_e         op_q;
  logic [IW-1:0] iter_q;

  logic [31:0] cfg_q [8];

  logic signed [47:0] npos_q, epos_q;
  logic signed [31:0] head_q, nrate_q, erate_q, trate_q;

  logic signed [31:0] fl_q, fr_q;
  logic signed [32:0] sum_q, dif_q;
  logic signed [33:0] ang_q, x_q, y_q, z_q;
  logic               neg_q;

  logic signed [63:0] tmp_q, sq_q, c1_q, fn_q, fe_q, fa_q;
  logic signed [63:0] np_q, ep_q, hd_q, nr_q, er_q, tr_q;

  logic               out_valid_q;
  logic signed [47:0] out_np_q, out_ep_q;
  logic signed [31:0] out_hd_q, out_nr_q, out_er_q, out_tr_q;
  logic [31:0]        out_cost_q;

  mul_req_t           mreq;
  mul_stat_t          mstat;
  logic signed [63:0] mres;

  logic signed [63:0] op_a, op_base, wb;
  logic signed [33:0] op_b;
  logic [5:0]         op_sh;
  op_kind_e           op_kind;
  op_dest_e           op_dest;

  logic signed [33:0] cs, sn, dx, dy;
  logic               in_acc, commit_go;
  logic [64:0]        cost_sum;

  function automatic logic signed [33:0] abs32(input logic signed [31:0] r);
    logic signed [33:0] e;
    e = 34'(r);
    return r[31] ? -e : e;
  endfunction

  assign cs = neg_q ? -x_q : x_q;
  assign sn = neg_q ? -y_q : y_q;
  assign dx = y_q >>> iter_q;
  assign dy = x_q >>> iter_q;

  // operand table of the force, integration and effort cost sequence
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_sh   = '0;
    op_kind = OPK_LOAD;
    op_base = tmp_q;
    op_dest = DST_TMP;
    case (op_q)
      OP_SUM_COS: begin op_a = 64'(sum_q); op_b = cs; op_sh = 6'd29; end
      OP_NSQ: begin
        op_a = 64'(nrate_q); op_b = abs32(nrate_q); op_dest = DST_SQ;
      end
      OP_FN: begin
        op_a = sq_q; op_b = 34'(cfg_q[REG_DRAG]); op_sh = 6'd16;
        op_kind = OPK_SUB; op_dest = DST_FN;
      end
      OP_SUM_SIN: begin op_a = 64'(sum_q); op_b = sn; op_sh = 6'd29; end
      OP_ESQ: begin
        op_a = 64'(erate_q); op_b = abs32(erate_q); op_dest = DST_SQ;
      end
      OP_FE: begin
        op_a = sq_q; op_b = 34'(cfg_q[REG_DRAG]); op_sh = 6'd16;
        op_kind = OPK_SUB; op_dest = DST_FE;
      end
      OP_DIF_ARM: begin
        op_a = 64'(dif_q); op_b = 34'(cfg_q[REG_LEVER_ARM]); op_sh = 6'd15;
      end
      OP_TSQ: begin
        op_a = 64'(trate_q); op_b = abs32(trate_q); op_dest = DST_SQ;
      end
      OP_FA: begin
        op_a = sq_q; op_b = 34'(cfg_q[REG_TURN_DRAG]); op_sh = 6'd16;
        op_kind = OPK_SUB; op_dest = DST_FA;
      end
      OP_NP_RATE: begin
        op_a = 64'(nrate_q); op_b = 34'(cfg_q[REG_STEP_TIME]); op_sh = 6'd16;
        op_kind = OPK_ADD; op_base = 64'(npos_q); op_dest = DST_NP;
      end
      OP_NP_FORCE: begin
        op_a = fn_q; op_b = 34'(cfg_q[REG_POS_GAIN]); op_sh = 6'd32;
        op_kind = OPK_ADD; op_base = np_q; op_dest = DST_NP;
      end
      OP_EP_RATE: begin
        op_a = 64'(erate_q); op_b = 34'(cfg_q[REG_STEP_TIME]); op_sh = 6'd16;
        op_kind = OPK_ADD; op_base = 64'(epos_q); op_dest = DST_EP;
      end
      OP_EP_FORCE: begin
        op_a = fe_q; op_b = 34'(cfg_q[REG_POS_GAIN]); op_sh = 6'd32;
        op_kind = OPK_ADD; op_base = ep_q; op_dest = DST_EP;
      end
      OP_HD_RATE: begin
        op_a = 64'(trate_q); op_b = 34'(cfg_q[REG_STEP_TIME]); op_sh = 6'd8;
        op_kind = OPK_ADD; op_base = 64'(head_q); op_dest = DST_HD;
      end
      OP_HD_FORCE: begin
        op_a = fa_q; op_b = 34'(cfg_q[REG_ANG_GAIN]); op_sh = 6'd24;
        op_kind = OPK_ADD; op_base = hd_q; op_dest = DST_HD;
      end
      OP_NR: begin
        op_a = fn_q; op_b = 34'(cfg_q[REG_VEL_GAIN]); op_sh = 6'd32;
        op_kind = OPK_ADD; op_base = 64'(nrate_q); op_dest = DST_NR;
      end
      OP_ER: begin
        op_a = fe_q; op_b = 34'(cfg_q[REG_VEL_GAIN]); op_sh = 6'd32;
        op_kind = OPK_ADD; op_base = 64'(erate_q); op_dest = DST_ER;
      end
      OP_TR: begin
        op_a = fa_q; op_b = 34'(cfg_q[REG_TURN_GAIN]); op_sh = 6'd32;
        op_kind = OPK_ADD; op_base = 64'(trate_q); op_dest = DST_TR;
      end
      OP_COST_L: begin op_a = 64'(fl_q); op_b = 34'(fl_q); op_dest = DST_C1; end
      OP_COST_R: begin op_a = 64'(fr_q); op_b = 34'(fr_q); op_dest = DST_SQ; end
      default: ;
    endcase
  end

  always_comb begin
    case (op_kind)
      OPK_ADD: wb = sat_add64(op_base, mres);
      OPK_SUB: wb = sat_sub64(op_base, mres);
      default: wb = mres;
    endcase
  end

  assign cost_sum = 65'($unsigned(c1_q)) + 65'($unsigned(sq_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_i.valid) state_d = ST_REDUCE;
      ST_REDUCE: if (ang_q < PI_Q24 && ang_q >= -PI_Q24) state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_ROTATE;
      ST_ROTATE: if (iter_q == IW'(CORDIC_ITERATIONS - 1)) state_d = ST_MUL_START;
      ST_MUL_START: state_d = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (mstat.done && op_q == OP_COST_R) state_d = ST_COMMIT;
                    else if (mstat.done) state_d = ST_MUL_START;
      ST_COMMIT: if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    cfg_i.ready = 1'b1;
    mreq.start  = (state_q == ST_MUL_START);
    mreq.a      = op_a;
    mreq.b      = op_b;
    mreq.sh     = op_sh;
    commit_go   = (state_q == ST_COMMIT) && (!out_valid_q || out_o.ready);
  end

  assign in_acc = in_i.valid && in_i.ready;

  pts_mulshift u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mreq),
    .stat_o   (mstat),
    .result_o (mres)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      npos_q      <= '0;
      epos_q      <= '0;
      head_q      <= '0;
      nrate_q     <= '0;
      erate_q     <= '0;
      trate_q     <= '0;
      cfg_q[REG_STEP_TIME] <= 32'd65536;
      cfg_q[REG_POS_GAIN]  <= 32'd32768;
      cfg_q[REG_ANG_GAIN]  <= 32'd32768;
      cfg_q[REG_VEL_GAIN]  <= 32'd65536;
      cfg_q[REG_TURN_GAIN] <= 32'd65536;
      cfg_q[REG_DRAG]      <= 32'd0;
      cfg_q[REG_TURN_DRAG] <= 32'd0;
      cfg_q[REG_LEVER_ARM] <= 32'd65536;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.index < CFG_IDX_W'(8)) begin
        cfg_q[cfg_i.index[2:0]] <= cfg_i.data;
      end
      if (commit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (commit_go) begin
        npos_q  <= clamp48(np_q);
        epos_q  <= clamp48(ep_q);
        head_q  <= clamp32(hd_q);
        nrate_q <= clamp32(nr_q);
        erate_q <= clamp32(er_q);
        trate_q <= clamp32(tr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fl_q  <= {~in_i.left_thrust[31], in_i.left_thrust[30:0]};
      fr_q  <= {~in_i.right_thrust[31], in_i.right_thrust[30:0]};
      sum_q <= 33'($signed({~in_i.left_thrust[31], in_i.left_thrust[30:0]}))
             + 33'($signed({~in_i.right_thrust[31], in_i.right_thrust[30:0]}));
      dif_q <= 33'($signed({~in_i.left_thrust[31], in_i.left_thrust[30:0]}))
             - 33'($signed({~in_i.right_thrust[31], in_i.right_thrust[30:0]}));
      ang_q <= 34'(head_q);
      neg_q <= 1'b0;
    end
    case (state_q)
      ST_REDUCE: begin
        if (ang_q >= PI_Q24) ang_q <= ang_q - TWO_PI_Q24;
        else if (ang_q < -PI_Q24) ang_q <= ang_q + TWO_PI_Q24;
      end
      ST_FOLD: begin
        // fold into [-pi/2, pi/2]; when folded, both results get negated afterwards
        if (ang_q > HALF_PI_Q24) begin
          z_q <= (ang_q - PI_Q24) <<< 6;
          neg_q <= 1'b1;
        end else if (ang_q < -HALF_PI_Q24) begin
          z_q <= (ang_q + PI_Q24) <<< 6;
          neg_q <= 1'b1;
        end else begin
          z_q <= ang_q <<< 6;
        end
        x_q    <= CORDIC_GAIN_Q30;
        y_q    <= '0;
        iter_q <= '0;
        op_q   <= OP_SUM_COS;
      end
      ST_ROTATE: begin
        if (!z_q[33]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_q30(5'(iter_q));
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_q30(5'(iter_q));
        end
        iter_q <= iter_q + IW'(1);
      end
      ST_MUL_WAIT: begin
        if (mstat.done) begin
          case (op_dest)
            DST_TMP: tmp_q <= wb;
            DST_SQ:  sq_q  <= wb;
            DST_FN:  fn_q  <= wb;
            DST_FE:  fe_q  <= wb;
            DST_FA:  fa_q  <= wb;
            DST_NP:  np_q  <= wb;
            DST_EP:  ep_q  <= wb;
            DST_HD:  hd_q  <= wb;
            DST_NR:  nr_q  <= wb;
            DST_ER:  er_q  <= wb;
            DST_TR:  tr_q  <= wb;
            DST_C1:  c1_q  <= wb;
            default: ;
          endcase
          if (op_q != OP_COST_R) op_q <= op_e'(op_q + 5'd1);
        end
      end
      default: ;
    endcase
    if (commit_go) begin
      out_np_q   <= clamp48(np_q);
      out_ep_q   <= clamp48(ep_q);
      out_hd_q   <= clamp32(hd_q);
      out_nr_q   <= clamp32(nr_q);
      out_er_q   <= clamp32(er_q);
      out_tr_q   <= clamp32(tr_q);
      out_cost_q <= cost_sum[63:32];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.north_position = out_np_q;
  assign out_o.east_position  = out_ep_q;
  assign out_o.heading_angle  = out_hd_q;
  assign out_o.north_velocity = out_nr_q;
  assign out_o.east_velocity  = out_er_q;
  assign out_o.turn_velocity  = out_tr_q;
  assign out_o.effort_cost    = out_cost_q;

  `PTS_ASSERT_ALWAYS(a_mul_busy_in_wait,
    (mstat.busy |-> state_q == ST_MUL_WAIT), "multiplier busy outside wait state")
  `PTS_ASSERT(a_rot_bound,
    (state_q == ST_ROTATE |-> iter_q <= IW'(CORDIC_ITERATIONS - 1)),
    "CORDIC iteration count past its end")
  `PTS_ASSERT(a_out_from_commit,
    ($rose(out_valid_q) |-> $past(state_q) == ST_COMMIT), "result raised outside commit")
  `PTS_ASSERT(a_commit_not_clobber,
    (out_valid_q && !out_o.ready && state_q == ST_COMMIT |=> state_q == ST_COMMIT),
    "commit overran a stalled result")

endmodule

// ===== bench/pts_tb_if_note.sv =====
// Checker for the planar thrust dynamics step: predicts and compares results.
// Depends on pts_pkg and the channel interfaces pts_in_if, pts_out_if, pts_cfg_if.
module pts_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  pts_in_if.sink    in_mon,
  pts_out_if.sink   out_mon,
  pts_cfg_if.sink   cfg_mon,
  output int        errors_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  typedef struct packed {
    logic signed [47:0] npos;
    logic signed [47:0] epos;
    logic signed [31:0] head;
    logic signed [31:0] nrate;
    logic signed [31:0] erate;
    logic signed [31:0] trate;
    logic [31:0]        cost;
  } body_state_t;

  localparam int TRIG_STEPS = CORDIC_ITER_DEF;

  logic [31:0] cfg_regs [8];
  logic signed [63:0] b_npos, b_epos, b_head, b_nrate, b_erate, b_trate;
  body_state_t next_states [$];
  int errors;

  assign errors_o  = errors;
  assign pending_o = next_states.size();

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  // sign(a*b) * floor(|a||b| / 2^sh), saturated to 64 bits
  function automatic logic signed [63:0] scaled_mul(logic signed [63:0] a,
                                                    logic signed [63:0] b, int sh);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    logic neg;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    neg = a[63] != b[63];
    p = (128'(ma) * 128'(mb)) >> sh;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] lim(logic signed [63:0] v, int w);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -(64'sd1 <<< (w - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic logic signed [63:0] drag_force(logic signed [63:0] r,
                                                    logic [31:0] k);
    logic signed [63:0] absr;
    absr = r < 0 ? -r : r;
    return scaled_mul(r * absr, {32'd0, k}, 16);
  endfunction

  function automatic logic signed [63:0] atan_table(int i);
    case (i)
      0: return 843314857;  1: return 497837829;  2: return 263043837;
      3: return 133525159;  4: return 67021687;   5: return 33543516;
      6: return 16775851;   7: return 8388437;    8: return 4194283;
      9: return 2097149;    10: return 1048576;
      default: return i <= 30 ? (64'sd1 <<< (30 - i)) : 0;
    endcase
  endfunction

  task automatic heading_trig(input logic signed [63:0] ang,
                              output logic signed [63:0] sn, cs);
    logic signed [63:0] a, x, y, z, dx, dy, at;
    logic flip;
    a = ang; x = 64'sd652032874; y = 0; flip = 0;
    while (a >= 64'sd52707179) a -= 64'sd105414357;
    while (a < -64'sd52707179) a += 64'sd105414357;
    if (a > 64'sd26353589) begin
      a -= 64'sd52707179; flip = 1;
    end else if (a < -64'sd26353589) begin
      a += 64'sd52707179; flip = 1;
    end
    z = a * 64;
    for (int i = 0; i < TRIG_STEPS && i < 32; i++) begin
      at = atan_table(i);
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= at;
      end else begin
        x += dx; y -= dy; z += at;
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  task automatic advance_body(input logic [31:0] lcode, rcode);
    logic signed [63:0] fl, fr, sm, df, sn, cs, fn, fe, fa;
    logic signed [63:0] np, ep, hd, nr, er, tr;
    body_state_t r;
    fl = $signed({32'd0, lcode}) - 64'sd2147483648;
    fr = $signed({32'd0, rcode}) - 64'sd2147483648;
    sm = fl + fr;
    df = fl - fr;
    heading_trig(b_head, sn, cs);
    fn = add_sat(scaled_mul(sm, cs, 29), -drag_force(b_nrate, cfg_regs[REG_DRAG]));
    fe = add_sat(scaled_mul(sm, sn, 29), -drag_force(b_erate, cfg_regs[REG_DRAG]));
    fa = add_sat(scaled_mul(df, {32'd0, cfg_regs[REG_LEVER_ARM]}, 15),
                 -drag_force(b_trate, cfg_regs[REG_TURN_DRAG]));
    np = add_sat(add_sat(b_npos, scaled_mul(b_nrate, {32'd0, cfg_regs[REG_STEP_TIME]}, 16)),
                 scaled_mul(fn, {32'd0, cfg_regs[REG_POS_GAIN]}, 32));
    ep = add_sat(add_sat(b_epos, scaled_mul(b_erate, {32'd0, cfg_regs[REG_STEP_TIME]}, 16)),
                 scaled_mul(fe, {32'd0, cfg_regs[REG_POS_GAIN]}, 32));
    hd = add_sat(add_sat(b_head, scaled_mul(b_trate, {32'd0, cfg_regs[REG_STEP_TIME]}, 8)),
                 scaled_mul(fa, {32'd0, cfg_regs[REG_ANG_GAIN]}, 24));
    nr = add_sat(b_nrate, scaled_mul(fn, {32'd0, cfg_regs[REG_VEL_GAIN]}, 32));
    er = add_sat(b_erate, scaled_mul(fe, {32'd0, cfg_regs[REG_VEL_GAIN]}, 32));
    tr = add_sat(b_trate, scaled_mul(fa, {32'd0, cfg_regs[REG_TURN_GAIN]}, 32));
    b_npos = lim(np, 48); b_epos = lim(ep, 48); b_head = lim(hd, 32);
    b_nrate = lim(nr, 32); b_erate = lim(er, 32); b_trate = lim(tr, 32);
    r.npos = b_npos[47:0]; r.epos = b_epos[47:0]; r.head = b_head[31:0];
    r.nrate = b_nrate[31:0]; r.erate = b_erate[31:0]; r.trate = b_trate[31:0];
    r.cost = 32'((64'(fl * fl) + 64'(fr * fr)) >> 32);
    next_states.push_back(r);
  endtask

  task automatic report(string name, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %h actual %h at %0t", name, want, got, $realtime);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    body_state_t e;
    if (!rst_ni) begin
      cfg_regs = '{65536, 32768, 32768, 65536, 65536, 0, 0, 65536};
      b_npos = 0; b_epos = 0; b_head = 0; b_nrate = 0; b_erate = 0; b_trate = 0;
      next_states.delete();
      errors = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.index < 8)
        cfg_regs[cfg_mon.index[2:0]] = cfg_mon.data;
      if (in_mon.valid && in_mon.ready)
        advance_body(in_mon.left_thrust, in_mon.right_thrust);
      if (out_mon.valid && out_mon.ready) begin
        if (next_states.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result beat with nothing expected at %0t", $realtime);
        end else begin
          e = next_states.pop_front();
          if (out_mon.north_position !== e.npos) report("north_position", e.npos, out_mon.north_position);
          if (out_mon.east_position !== e.epos) report("east_position", e.epos, out_mon.east_position);
          if (out_mon.heading_angle !== e.head) report("heading_angle", e.head, out_mon.heading_angle);
          if (out_mon.north_velocity !== e.nrate) report("north_velocity", e.nrate, out_mon.north_velocity);
          if (out_mon.east_velocity !== e.erate) report("east_velocity", e.erate, out_mon.east_velocity);
          if (out_mon.turn_velocity !== e.trate) report("turn_velocity", e.trate, out_mon.turn_velocity);
          if (out_mon.effort_cost !== e.cost) report("effort_cost", e.cost, out_mon.effort_cost);
        end
      end
    end
  end
endmodule

// ===== bench/tb.sv =====
// Top of the planar thrust dynamics testbench: clock, reset, stimulus, verdict.
// Depends on pts_pkg, the channel interfaces, the RTL top and pts_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  int errors, pending;
  int send_idle, recv_idle;

  pts_in_if  in_ch();
  pts_out_if out_ch();
  pts_cfg_if cfg_ch();

  planar_thrust_dynamics_step dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  pts_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_mon(cfg_ch.sink), .errors_o(errors), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.left_thrust = 0; in_ch.right_thrust = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
  end

  // receiver stalls at random
  always @(posedge clk_i) out_ch.ready <= ($urandom_range(99) >= recv_idle);

  // valid stays up after the beat; drain() drops it, the next call only while it idles
  task automatic send_beat(input logic [31:0] lt, rt);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1;
    in_ch.left_thrust <= lt;
    in_ch.right_thrust <= rt;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= CFG_IDX_W'(idx);
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // mostly moderate thrust so the body stays off its limits; some full-range codes
  function automatic logic [31:0] rand_code();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'h8000_0000 + $urandom_range(32'h0100_0000) - 32'h0080_0000;
      default: return 32'h8000_0000 + $urandom_range(32'h1000_0000) - 32'h0800_0000;
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_beat(rand_code(), rand_code());
  endtask

  task automatic load_profile(input int p);
    logic [31:0] v;
    for (int r = 0; r < 8; r++) begin
      case (p)
        0: v = (r == REG_DRAG || r == REG_TURN_DRAG) ? 32'd0 : 32'h0000_FFFF;
        1: v = $urandom_range(32'h0002_0000);
        2: v = (r == REG_STEP_TIME || r == REG_LEVER_ARM) ? 32'h0000_4000 : $urandom_range(256);
        default: v = 32'hFFFF_FFFF;
      endcase
      write_reg(cfg_reg_e'(r), v);
    end
    cfg_ch.valid <= 0;
  endtask

  initial begin
    send_idle = 37; recv_idle = 60;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, zero force, full reverse both sides, opposing thrust
    send_beat(32'h8000_0000, 32'h8000_0000);
    send_beat(32'h0000_0000, 32'h0000_0000);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(32'hFFFF_FFFF, 32'h0000_0000);
    send_beat(32'h0000_0000, 32'hFFFF_FFFF);
    send_beat(32'hAAAA_AAAA, 32'h5555_5555);
    send_beat(32'h5555_5555, 32'hAAAA_AAAA);
    for (int i = 0; i < 8; i++) send_beat(32'hC000_0000, 32'h4000_0000);
    drain();
    random_phase(350);
    drain();
    load_profile(0);
    random_phase(150);
    drain();
    load_profile(1);
    send_idle = 60; recv_idle = 37;
    random_phase(400);
    drain();
    load_profile(2);
    random_phase(300);
    drain();
    load_profile(3);
    send_idle = 0; recv_idle = 0;
    random_phase(100);
    drain();
    load_profile(1);
    random_phase(450);
    drain();
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end
endmodule
